@@ design/ptd_pkg.sv @@
// ----------------------------------------------------------------------------
// ptd_pkg: shared types and constants for the trial-division prime tester
// Holds the controller state enum, the command/status structs passed
// between controller and datapath, and the default operand width.
// ----------------------------------------------------------------------------
package ptd_pkg;

  // Default width of the tested number
  localparam int unsigned NUM_WIDTH_DEF = 32;

  // First odd trial divisor and the stride between divisors
  localparam int unsigned FIRST_DIV = 3;
  localparam int unsigned DIV_STRIDE = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EVAL
  } ptd_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture number, reset divisor
    logic div_start;   // begin a new remainder computation
    logic div_step;    // one restoring-division step
    logic div_next;    // advance divisor to the next odd value
    logic res_wr;      // write the result register
    logic res_val;     // value to write
  } ptd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_two;      // number equals two
    logic is_trivial;  // number below two or even
    logic div_last;    // final division step this cycle
    logic d_gt_q;      // divisor exceeds quotient: search exhausted
    logic rem_zero;    // remainder is zero: divisor found
  } ptd_sts_t;

endpackage

@@ design/prime_test_trial_division_top.sv @@
// ----------------------------------------------------------------------------
// prime_test_trial_division_top: trial-division primality tester
// Reports whether an unsigned number is prime by dividing it by odd
// divisors up to its square root.
// ----------------------------------------------------------------------------
// Operation: zero, one, two and even numbers are settled in the check
//   state without division; other numbers run the bit-serial divider
//   once per trial divisor (one quotient bit per cycle, NUM_WIDTH steps each).
// Throughput: one number at a time; the worst case for 32 bits tries
//   about 32768 divisors.
// Reset: rst_ni asynchronously returns the controller to idle and drops
//   out_valid_o; no clearing pass.
// ----------------------------------------------------------------------------
module prime_test_trial_division_top #(
  parameter int unsigned NUM_WIDTH = ptd_pkg::NUM_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input beat: number to test
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [NUM_WIDTH-1:0] number_i,
  // Output beat: verdict
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 is_prime_o
);

  ptd_pkg::ptd_cmd_t cmd;
  ptd_pkg::ptd_sts_t sts;

  // Controller: special-case check, division sequencing, search loop.
  // The result register decouples the output side, so a new beat is
  // accepted while the previous verdict still waits to be taken.
  ptd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: number and divisor registers, restoring divider giving
  // quotient and remainder; the search stops when divisor > quotient
  // (equivalent to divisor squared > number) or the remainder is zero.
  ptd_dpath #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .number_i   (number_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .is_prime_o (is_prime_o)
  );

endmodule

@@ design/ptd_dpath.sv @@
// ----------------------------------------------------------------------------
// ptd_dpath: datapath of the trial-division prime tester
// Holds the number, the odd trial divisor, a bit-serial restoring divider
// that yields quotient and remainder, and the result register.
// ----------------------------------------------------------------------------
module ptd_dpath #(
  parameter int unsigned NUM_WIDTH = ptd_pkg::NUM_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [NUM_WIDTH-1:0] number_i,
  input  ptd_pkg::ptd_cmd_t    cmd_i,
  output ptd_pkg::ptd_sts_t    sts_o,
  output logic                 is_prime_o
);

  localparam int unsigned CNT_W = $clog2(NUM_WIDTH);

  logic [NUM_WIDTH-1:0] num_q, num_d;
  logic [NUM_WIDTH-1:0] div_q, div_d;
  logic [NUM_WIDTH-1:0] rem_q, rem_d;
  logic [NUM_WIDTH-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 res_q, res_d;

  logic [NUM_WIDTH:0]   partial;
  logic [NUM_WIDTH:0]   diff;
  logic                 fits;

  // One restoring step: shift in next dividend bit, subtract if it fits
  assign partial = {rem_q, quo_q[NUM_WIDTH-1]};
  assign diff    = partial - {1'b0, div_q};
  assign fits    = (partial >= {1'b0, div_q});

  always_comb begin
    num_d = num_q;
    div_d = div_q;
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    res_d = res_q;
    if (cmd_i.load) begin
      num_d = number_i;
      div_d = NUM_WIDTH'(ptd_pkg::FIRST_DIV);
    end
    if (cmd_i.div_next) begin
      div_d = div_q + NUM_WIDTH'(ptd_pkg::DIV_STRIDE);
    end
    if (cmd_i.div_start) begin
      rem_d = '0;
      quo_d = num_q;
      cnt_d = CNT_W'(NUM_WIDTH - 1);
    end else if (cmd_i.div_step) begin
      rem_d = fits ? diff[NUM_WIDTH-1:0] : partial[NUM_WIDTH-1:0];
      quo_d = {quo_q[NUM_WIDTH-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
    end
    if (cmd_i.res_wr) begin
      res_d = cmd_i.res_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    res_q <= res_d;
  end

  assign sts_o.is_two     = (num_q == NUM_WIDTH'(2));
  assign sts_o.is_trivial = (num_q < NUM_WIDTH'(2)) || !num_q[0];
  assign sts_o.div_last   = (cnt_q == '0);
  assign sts_o.d_gt_q     = (div_q > quo_q);
  assign sts_o.rem_zero   = (rem_q == '0);

  assign is_prime_o = res_q;

endmodule

@@ design/ptd_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptd_ctrl: controller of the trial-division prime tester
// Sequences the special-case check, the per-divisor division and the
// divisor search, and owns the output valid flag.
// ----------------------------------------------------------------------------
module ptd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ptd_pkg::ptd_sts_t sts_i,
  output ptd_pkg::ptd_cmd_t cmd_o
);

  ptd_pkg::ptd_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  // Result register can take a new value this cycle
  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ptd_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ptd_pkg::ST_CHECK;
      end
      ptd_pkg::ST_CHECK: begin
        if (sts_i.is_two || sts_i.is_trivial) begin
          if (out_free) state_d = ptd_pkg::ST_IDLE;
        end else begin
          state_d = ptd_pkg::ST_DIV;
        end
      end
      ptd_pkg::ST_DIV: begin
        if (sts_i.div_last) state_d = ptd_pkg::ST_EVAL;
      end
      ptd_pkg::ST_EVAL: begin
        if (sts_i.d_gt_q || sts_i.rem_zero) begin
          if (out_free) state_d = ptd_pkg::ST_IDLE;
        end else begin
          state_d = ptd_pkg::ST_DIV;
        end
      end
      default: state_d = ptd_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ptd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ptd_pkg::ST_CHECK: begin
        if (sts_i.is_two || sts_i.is_trivial) begin
          cmd_o.res_wr  = out_free;
          cmd_o.res_val = sts_i.is_two;
        end else begin
          cmd_o.div_start = 1'b1;
        end
      end
      ptd_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ptd_pkg::ST_EVAL: begin
        if (sts_i.d_gt_q || sts_i.rem_zero) begin
          cmd_o.res_wr  = out_free;
          cmd_o.res_val = sts_i.d_gt_q;
        end else begin
          cmd_o.div_next  = 1'b1;
          cmd_o.div_start = 1'b1;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.res_wr) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
